// ===== src/pcxd_pkg.sv =====
package pcxd_pkg;

  // Item kinds on the byte channel.
  typedef enum logic [1:0] {
    CMD_PALETTE = 2'd0,
    CMD_HEADER  = 2'd1,
    CMD_DATA    = 2'd2,
    CMD_EOF     = 2'd3
  } cmd_t;

  // Status codes on the pixel channel.
  typedef enum logic [1:0] {
    ST_PIXEL      = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_NO_MARKER  = 2'd2,
    ST_TRUNCATED  = 2'd3
  } status_t;

  // Palette geometry.
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);

  // Trailer and header lengths in bytes.
  localparam logic [9:0] TRAILER_LEN = 10'd769;
  localparam logic [7:0] HEADER_LEN  = 8'd128;

  // Fixed byte values.
  localparam logic [7:0] PAL_MARKER  = 8'h0c;
  localparam logic [7:0] MANUF_ID    = 8'h0a;
  localparam logic [7:0] VERSION_ID  = 8'd5;
  localparam logic [7:0] ENCODING_ID = 8'd1;
  localparam logic [7:0] BPP_ID      = 8'd8;
  localparam logic [7:0] PLANES_ID   = 8'd1;

  // Header byte offsets that carry meaning.
  localparam logic [7:0] HDR_MANUF    = 8'd0;
  localparam logic [7:0] HDR_VERSION  = 8'd1;
  localparam logic [7:0] HDR_ENCODING = 8'd2;
  localparam logic [7:0] HDR_BPP      = 8'd3;
  localparam logic [7:0] HDR_XMAX_LO  = 8'd8;
  localparam logic [7:0] HDR_XMAX_HI  = 8'd9;
  localparam logic [7:0] HDR_YMAX_LO  = 8'd10;
  localparam logic [7:0] HDR_YMAX_HI  = 8'd11;
  localparam logic [7:0] HDR_PLANES   = 8'd65;

  // Run marker: top two bits set, count in the low six.
  localparam logic [1:0] RUN_TAG = 2'b11;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Write request into the palette memory.
  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    rgb_t              data;
  } pal_wr_t;

endpackage

// ===== src/pcxd_if.sv =====
// Input byte channel.
interface pcxd_byte_if;
  logic                valid;
  logic                ready;
  pcxd_pkg::cmd_t      cmd;
  logic [7:0]          data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// Output pixel channel.
interface pcxd_pixel_if;
  logic                valid;
  logic                ready;
  logic [7:0]          red;
  logic [7:0]          green;
  logic [7:0]          blue;
  logic                final_pixel;
  pcxd_pkg::status_t   status;
  logic [9:0]          image_width;
  logic [9:0]          image_height;

  modport source (output valid, output red, output green, output blue, output final_pixel,
                  output status, output image_width, output image_height, input ready);
  modport sink   (input valid, input red, input green, input blue, input final_pixel,
                  input status, input image_width, input image_height, output ready);
endinterface

// ===== src/pcxd_palette_ram.sv =====
// Palette memory: one write port and one registered read port.
module pcxd_palette_ram (
  input  logic                      clk,
  input  pcxd_pkg::pal_wr_t         wr,
  input  logic                      rd_en,
  input  logic [pcxd_pkg::PAL_AW-1:0] rd_addr,
  output pcxd_pkg::rgb_t            rd_data
);

  pcxd_pkg::rgb_t mem [pcxd_pkg::PAL_ENTRIES];

  // Write a whole entry; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/pcx_rle_palette_decoder.sv =====
// Decodes an 8-bit PCX image into RGB pixels. Feed the 769-byte palette trailer first
// (marker byte, then 256 RGB triples), then the 128 header bytes, then the RLE data bytes,
// and close each image with an end-of-file item. Trailer and header bytes are taken one per
// cycle while no beat waits in the output register. A successful header passes through a
// load state that forms the pixel count. A literal data byte is read from the palette RAM,
// then goes out as a pixel beat. A run byte arms the run, and the value byte after it gives
// a run of N pixels, one pixel per cycle while the output is free, from the single palette
// RAM read port. Input is held off while a run drains. Status beats (bad header, missing
// palette marker, truncated data) come out in the cycle after the byte that causes them. A
// beat that waits in the output register holds off the next byte until it is taken. The
// palette memory is not cleared on reset; decoding starts only after a full trailer.
module pcx_rle_palette_decoder #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                clk,
  input  logic                rst,
  pcxd_byte_if.sink           byte_ch,
  pcxd_pixel_if.source        pixel_ch
);

  localparam int SW = $clog2(MAX_SIDE);
  localparam int PW = 2 * SW;

  typedef enum logic [1:0] {S_IN, S_LOAD, S_EMIT} state_t;

  state_t                      state;
  logic [9:0]                  pal_count;
  logic                        marker_seen;
  logic [1:0]                  phase;
  logic [pcxd_pkg::PAL_AW-1:0] entry_idx;
  logic [7:0]                  red_buf;
  logic [7:0]                  green_buf;
  logic [7:0]                  hdr_count;
  logic                        header_ok;
  logic [15:0]                 width_reg;
  logic [15:0]                 height_reg;
  logic [PW-1:0]               pixels_left;
  logic [5:0]                  run_pending;
  logic                        awaiting;

  logic                        o_valid;
  pcxd_pkg::rgb_t              o_rgb;
  logic                        o_final;
  pcxd_pkg::status_t           o_status;
  logic [9:0]                  o_width;
  logic [9:0]                  o_height;

  logic                        out_free;
  logic                        acc;
  logic                        pal_take;
  logic                        dec_active;
  logic                        is_run;
  logic                        byte_ok;
  logic                        hdr_ok_now;
  logic [15:0]                 w_next;
  logic [15:0]                 h_next;
  logic                        side_bad;
  pcxd_pkg::pal_wr_t           pal_wr;
  logic                        rd_en;
  pcxd_pkg::rgb_t              rd_data;

  pcxd_palette_ram u_ram (
    .clk     (clk),
    .wr      (pal_wr),
    .rd_en   (rd_en),
    .rd_addr (byte_ch.data_byte[pcxd_pkg::PAL_AW-1:0]),
    .rd_data (rd_data)
  );

  // Handshake and decode of the current byte.
  always_comb begin
    out_free   = !o_valid || pixel_ch.ready;
    acc        = byte_ch.valid && byte_ch.ready;
    dec_active = (pixels_left != '0);
    is_run     = (byte_ch.data_byte[7:6] == pcxd_pkg::RUN_TAG);
    pal_take   = acc && (byte_ch.cmd == pcxd_pkg::CMD_PALETTE) && (hdr_count == '0) &&
                 (pal_count < pcxd_pkg::TRAILER_LEN);
    rd_en      = acc && (byte_ch.cmd == pcxd_pkg::CMD_DATA) && dec_active &&
                 (awaiting ? (run_pending != '0) : !is_run);
  end

  // Trailer bytes gather into a full entry, written on the blue byte.
  always_comb begin
    pal_wr.en   = pal_take && (pal_count != '0) && (phase == 2'd2);
    pal_wr.addr = entry_idx;
    pal_wr.data = '{red: red_buf, green: green_buf, blue: byte_ch.data_byte};
  end

  // Header field checks and the size check on the last header byte.
  always_comb begin
    case (hdr_count)
      pcxd_pkg::HDR_MANUF:    byte_ok = (byte_ch.data_byte == pcxd_pkg::MANUF_ID);
      pcxd_pkg::HDR_VERSION:  byte_ok = (byte_ch.data_byte == pcxd_pkg::VERSION_ID);
      pcxd_pkg::HDR_ENCODING: byte_ok = (byte_ch.data_byte == pcxd_pkg::ENCODING_ID);
      pcxd_pkg::HDR_BPP:      byte_ok = (byte_ch.data_byte == pcxd_pkg::BPP_ID);
      pcxd_pkg::HDR_PLANES:   byte_ok = (byte_ch.data_byte == pcxd_pkg::PLANES_ID);
      default:                byte_ok = 1'b1;
    endcase
    hdr_ok_now = header_ok && byte_ok;
    w_next     = width_reg + 16'd1;
    h_next     = height_reg + 16'd1;
    side_bad   = (w_next == '0) || (h_next == '0) ||
                 (w_next >= 16'(MAX_SIDE)) || (h_next >= 16'(MAX_SIDE));
  end

  assign byte_ch.ready = (state == S_IN) && out_free;

  // Control sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IN;
      o_valid     <= 1'b0;
      pal_count   <= '0;
      marker_seen <= 1'b0;
      phase       <= '0;
      entry_idx   <= '0;
      hdr_count   <= '0;
      header_ok   <= 1'b1;
      width_reg   <= '0;
      height_reg  <= '0;
      pixels_left <= '0;
      run_pending <= '0;
      awaiting    <= 1'b0;
    end else begin
      if (o_valid && pixel_ch.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IN: begin
          if (acc) begin
            case (byte_ch.cmd)
              pcxd_pkg::CMD_PALETTE: begin
                if (pal_take) begin
                  pal_count <= pal_count + 10'd1;
                  if (pal_count == '0) begin
                    marker_seen <= (byte_ch.data_byte == pcxd_pkg::PAL_MARKER);
                  end else if (phase == 2'd0) begin
                    red_buf <= byte_ch.data_byte;
                    phase   <= 2'd1;
                  end else if (phase == 2'd1) begin
                    green_buf <= byte_ch.data_byte;
                    phase     <= 2'd2;
                  end else begin
                    phase     <= 2'd0;
                    entry_idx <= entry_idx + 1'b1;
                  end
                end
              end
              pcxd_pkg::CMD_HEADER: begin
                if (hdr_count < pcxd_pkg::HEADER_LEN) begin
                  hdr_count <= hdr_count + 8'd1;
                  header_ok <= hdr_ok_now;
                  case (hdr_count)
                    pcxd_pkg::HDR_XMAX_LO: width_reg[7:0]   <= byte_ch.data_byte;
                    pcxd_pkg::HDR_XMAX_HI: width_reg[15:8]  <= byte_ch.data_byte;
                    pcxd_pkg::HDR_YMAX_LO: height_reg[7:0]  <= byte_ch.data_byte;
                    pcxd_pkg::HDR_YMAX_HI: height_reg[15:8] <= byte_ch.data_byte;
                    default: ;
                  endcase
                  // Last header byte: check sizes and palette, then start or fail.
                  if (hdr_count == pcxd_pkg::HEADER_LEN - 8'd1) begin
                    width_reg  <= w_next;
                    height_reg <= h_next;
                    header_ok  <= hdr_ok_now && !side_bad;
                    if (!hdr_ok_now || side_bad) begin
                      o_valid  <= 1'b1;
                      o_rgb    <= '0;
                      o_final  <= 1'b0;
                      o_status <= pcxd_pkg::ST_BAD_HEADER;
                      o_width  <= '0;
                      o_height <= '0;
                    end else if (!marker_seen || (pal_count != pcxd_pkg::TRAILER_LEN)) begin
                      o_valid  <= 1'b1;
                      o_rgb    <= '0;
                      o_final  <= 1'b0;
                      o_status <= pcxd_pkg::ST_NO_MARKER;
                      o_width  <= '0;
                      o_height <= '0;
                    end else begin
                      run_pending <= '0;
                      awaiting    <= 1'b0;
                      state       <= S_LOAD;
                    end
                  end
                end
              end
              pcxd_pkg::CMD_DATA: begin
                if (dec_active) begin
                  if (awaiting) begin
                    awaiting <= 1'b0;
                    if (run_pending != '0) begin
                      state <= S_EMIT;
                    end
                  end else if (is_run) begin
                    run_pending <= byte_ch.data_byte[5:0];
                    awaiting    <= 1'b1;
                  end else begin
                    run_pending <= 6'd1;
                    state       <= S_EMIT;
                  end
                end
              end
              pcxd_pkg::CMD_EOF: begin
                if ((hdr_count < pcxd_pkg::HEADER_LEN) || dec_active) begin
                  o_valid  <= 1'b1;
                  o_rgb    <= '0;
                  o_final  <= 1'b0;
                  o_status <= pcxd_pkg::ST_TRUNCATED;
                  o_width  <= '0;
                  o_height <= '0;
                end
                pal_count   <= '0;
                marker_seen <= 1'b0;
                phase       <= '0;
                entry_idx   <= '0;
                hdr_count   <= '0;
                header_ok   <= 1'b1;
                width_reg   <= '0;
                height_reg  <= '0;
                pixels_left <= '0;
                run_pending <= '0;
                awaiting    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        // Sides are below MAX_SIDE here, so SW bits of each hold them.
        S_LOAD: begin
          pixels_left <= PW'(width_reg[SW-1:0]) * PW'(height_reg[SW-1:0]);
          state       <= S_IN;
        end
        // Drain the run, one pixel beat per cycle while the output is free, cut short at the last pixel.
        S_EMIT: begin
          if (out_free) begin
            o_valid     <= 1'b1;
            o_rgb       <= rd_data;
            o_final     <= (pixels_left == PW'(1));
            o_status    <= pcxd_pkg::ST_PIXEL;
            o_width     <= width_reg[9:0];
            o_height    <= height_reg[9:0];
            pixels_left <= pixels_left - PW'(1);
            run_pending <= run_pending - 6'd1;
            if ((run_pending == 6'd1) || (pixels_left == PW'(1))) begin
              state <= S_IN;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  assign pixel_ch.valid        = o_valid;
  assign pixel_ch.red          = o_rgb.red;
  assign pixel_ch.green        = o_rgb.green;
  assign pixel_ch.blue         = o_rgb.blue;
  assign pixel_ch.final_pixel  = o_final;
  assign pixel_ch.status       = o_status;
  assign pixel_ch.image_width  = o_width;
  assign pixel_ch.image_height = o_height;

`ifndef ASSERT_OFF
  // A run is only drained while pixels and copies are still owed.
  a_emit_owed: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ((pixels_left != '0) && (run_pending != '0)))
    else $error("run drain with nothing owed");

  // The final flag goes out exactly on the beat that uses up the pixel count.
  a_final_flag: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && out_free) |=> (o_final == (pixels_left == '0)))
    else $error("final pixel flag out of step with pixel count");

  // The trailer counter never runs past the trailer length.
  a_trailer_bound: assert property (@(posedge clk) disable iff (rst)
    pal_count <= pcxd_pkg::TRAILER_LEN)
    else $error("palette byte count past trailer length");

  // No palette write once the header has started.
  a_late_palette: assert property (@(posedge clk) disable iff (rst)
    pal_wr.en |-> (hdr_count == '0))
    else $error("palette write after header start");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_SIDE = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int TRAILER_BYTES = 769;
  localparam int HEADER_BYTES = 128;

  // Ways a header can be spoiled on purpose.
  typedef enum int {
    HDR_GOOD,
    BAD_MANUF,
    BAD_VERSION,
    BAD_ENCODING,
    BAD_BPP,
    BAD_PLANES
  } hdr_fault_t;

  typedef struct {
    pcxd_pkg::cmd_t cmd;
    logic [7:0]     data;
  } file_byte_t;

  typedef struct {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              final_pixel;
    pcxd_pkg::status_t status;
    logic [9:0]        image_width;
    logic [9:0]        image_height;
  } pixel_t;

  logic clk;
  logic rst;

  pcxd_byte_if  byte_ch ();
  pcxd_pixel_if pixel_ch ();

  pcx_rle_palette_decoder #(
    .MAX_SIDE (MAX_SIDE)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .pixel_ch (pixel_ch)
  );

  file_byte_t file_bytes[$];
  pixel_t     expected_pixels[$];
  int         bytes_total;
  int         bytes_taken;
  int         mismatches;
  int         cycle_count;

  // Decoder state as the checker sees it.
  pcxd_pkg::rgb_t pal[pcxd_pkg::PAL_ENTRIES];
  int             pal_cnt;
  bit             marker_ok;
  int             hdr_cnt;
  bit             hdr_ok;
  logic [15:0]    wreg;
  logic [15:0]    hreg;
  int             px_left;
  int             run_cnt;
  bit             run_armed;

  // Sender burst and gap bookkeeping.
  int          burst_left;
  int          gap_left;
  file_byte_t  next_byte;
  logic [9:0]  rx_phase;
  pixel_t      want_px;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH: %s", msg);
    end
  endfunction

  function automatic void clear_decode();
    pal_cnt = 0;
    marker_ok = 1'b0;
    hdr_cnt = 0;
    hdr_ok = 1'b1;
    wreg = '0;
    hreg = '0;
    px_left = 0;
    run_cnt = 0;
    run_armed = 1'b0;
  endfunction

  function automatic void push_status(input pcxd_pkg::status_t code);
    pixel_t p;
    p.red = '0;
    p.green = '0;
    p.blue = '0;
    p.final_pixel = 1'b0;
    p.status = code;
    p.image_width = '0;
    p.image_height = '0;
    expected_pixels.push_back(p);
  endfunction

  // Emits up to count copies of one palette color, never past the image end.
  function automatic void emit_run(input logic [7:0] idx, input int count);
    pixel_t p;
    while (count > 0 && px_left > 0) begin
      px_left--;
      count--;
      p.red = pal[idx].red;
      p.green = pal[idx].green;
      p.blue = pal[idx].blue;
      p.final_pixel = (px_left == 0);
      p.status = pcxd_pkg::ST_PIXEL;
      p.image_width = wreg[9:0];
      p.image_height = hreg[9:0];
      expected_pixels.push_back(p);
    end
  endfunction

  // Advances the decoder state by one accepted byte and queues what it yields.
  function automatic void decode_byte(input pcxd_pkg::cmd_t c, input logic [7:0] b);
    int pos;
    case (c)
      pcxd_pkg::CMD_PALETTE: begin
        if (hdr_cnt == 0 && pal_cnt < TRAILER_BYTES) begin
          if (pal_cnt == 0) begin
            marker_ok = (b == pcxd_pkg::PAL_MARKER);
          end else begin
            pos = pal_cnt - 1;
            case (pos % 3)
              0: pal[pos / 3].red = b;
              1: pal[pos / 3].green = b;
              default: pal[pos / 3].blue = b;
            endcase
          end
          pal_cnt++;
        end
      end
      pcxd_pkg::CMD_HEADER: begin
        if (hdr_cnt < HEADER_BYTES) begin
          case (hdr_cnt)
            pcxd_pkg::HDR_MANUF:    if (b != pcxd_pkg::MANUF_ID) hdr_ok = 1'b0;
            pcxd_pkg::HDR_VERSION:  if (b != pcxd_pkg::VERSION_ID) hdr_ok = 1'b0;
            pcxd_pkg::HDR_ENCODING: if (b != pcxd_pkg::ENCODING_ID) hdr_ok = 1'b0;
            pcxd_pkg::HDR_BPP:      if (b != pcxd_pkg::BPP_ID) hdr_ok = 1'b0;
            pcxd_pkg::HDR_XMAX_LO:  wreg[7:0] = b;
            pcxd_pkg::HDR_XMAX_HI:  wreg[15:8] = b;
            pcxd_pkg::HDR_YMAX_LO:  hreg[7:0] = b;
            pcxd_pkg::HDR_YMAX_HI:  hreg[15:8] = b;
            pcxd_pkg::HDR_PLANES:   if (b != pcxd_pkg::PLANES_ID) hdr_ok = 1'b0;
            default: ;
          endcase
          hdr_cnt++;
          if (hdr_cnt == HEADER_BYTES) begin
            wreg = wreg + 16'd1;
            hreg = hreg + 16'd1;
            if (wreg == 0 || hreg == 0 || wreg >= MAX_SIDE || hreg >= MAX_SIDE) begin
              hdr_ok = 1'b0;
            end
            if (!hdr_ok) begin
              push_status(pcxd_pkg::ST_BAD_HEADER);
            end else if (!marker_ok || pal_cnt < TRAILER_BYTES) begin
              push_status(pcxd_pkg::ST_NO_MARKER);
            end else begin
              px_left = int'(wreg) * int'(hreg);
              run_cnt = 0;
              run_armed = 1'b0;
            end
          end
        end
      end
      pcxd_pkg::CMD_DATA: begin
        if (px_left != 0) begin
          if (run_armed) begin
            run_armed = 1'b0;
            emit_run(b, run_cnt);
          end else if (b[7:6] == pcxd_pkg::RUN_TAG) begin
            run_cnt = b[5:0];
            run_armed = 1'b1;
          end else begin
            emit_run(b, 1);
          end
        end
      end
      default: begin
        if (hdr_cnt < HEADER_BYTES || px_left > 0) begin
          push_status(pcxd_pkg::ST_TRUNCATED);
        end
        clear_decode();
      end
    endcase
  endfunction

  function automatic void put_byte(input pcxd_pkg::cmd_t c, input logic [7:0] b);
    file_byte_t fb;
    fb.cmd = c;
    fb.data = b;
    file_bytes.push_back(fb);
  endfunction

  // Marker byte then n-1 color bytes; with pin_ends, entry 0 is black and 255 white.
  function automatic void put_trailer(input int n, input logic [7:0] first, input bit pin_ends);
    logic [7:0] b;
    if (n > 0) begin
      put_byte(pcxd_pkg::CMD_PALETTE, first);
    end
    for (int i = 1; i < n; i++) begin
      b = 8'($urandom);
      if (pin_ends && i <= 3) begin
        b = 8'h00;
      end else if (pin_ends && i >= 766) begin
        b = 8'hff;
      end
      put_byte(pcxd_pkg::CMD_PALETTE, b);
    end
  endfunction

  function automatic logic [7:0] id_byte(input logic [7:0] good, input bit spoil);
    return spoil ? (good ^ 8'($urandom_range(1, 255))) : good;
  endfunction

  function automatic void put_header(input logic [15:0] xmax, input logic [15:0] ymax,
                                     input hdr_fault_t fault);
    logic [7:0] b;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      b = 8'($urandom);
      case (i)
        pcxd_pkg::HDR_MANUF:    b = id_byte(pcxd_pkg::MANUF_ID, fault == BAD_MANUF);
        pcxd_pkg::HDR_VERSION:  b = id_byte(pcxd_pkg::VERSION_ID, fault == BAD_VERSION);
        pcxd_pkg::HDR_ENCODING: b = id_byte(pcxd_pkg::ENCODING_ID, fault == BAD_ENCODING);
        pcxd_pkg::HDR_BPP:      b = id_byte(pcxd_pkg::BPP_ID, fault == BAD_BPP);
        pcxd_pkg::HDR_PLANES:   b = id_byte(pcxd_pkg::PLANES_ID, fault == BAD_PLANES);
        pcxd_pkg::HDR_XMAX_LO:  b = xmax[7:0];
        pcxd_pkg::HDR_XMAX_HI:  b = xmax[15:8];
        pcxd_pkg::HDR_YMAX_LO:  b = ymax[7:0];
        pcxd_pkg::HDR_YMAX_HI:  b = ymax[15:8];
        default: ;
      endcase
      put_byte(pcxd_pkg::CMD_HEADER, b);
    end
  endfunction

  // Compressed data worth at least count pixels: literals, runs and zero runs.
  // The last run may overshoot, which exercises the excess-pixel cut.
  function automatic void put_pixels(input int count);
    int left;
    int n;
    left = count;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          put_byte(pcxd_pkg::CMD_DATA, 8'($urandom_range(0, 191)));
          left--;
        end
        5: begin
          put_byte(pcxd_pkg::CMD_DATA, {pcxd_pkg::RUN_TAG, 6'd0});
          put_byte(pcxd_pkg::CMD_DATA, 8'($urandom));
        end
        default: begin
          n = $urandom_range(1, 63);
          put_byte(pcxd_pkg::CMD_DATA, {pcxd_pkg::RUN_TAG, 6'(n)});
          put_byte(pcxd_pkg::CMD_DATA, 8'($urandom));
          left -= n;
        end
      endcase
    end
  endfunction

  // One random image: mostly well formed, sometimes broken or cut short.
  function automatic void put_random_image();
    int pick;
    int w;
    int h;
    int pixels;
    hdr_fault_t fault;
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      put_trailer(TRAILER_BYTES, pcxd_pkg::PAL_MARKER, 1'b0);
    end else if (pick == 8) begin
      put_trailer(TRAILER_BYTES, 8'($urandom), 1'b0);
    end else begin
      put_trailer($urandom_range(0, TRAILER_BYTES - 1), pcxd_pkg::PAL_MARKER, 1'b0);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) put_byte(pcxd_pkg::CMD_PALETTE, 8'($urandom));
    end
    if ($urandom_range(0, 5) == 0) begin
      put_byte(pcxd_pkg::CMD_DATA, 8'($urandom));
    end
    w = $urandom_range(1, 12);
    h = $urandom_range(1, 12);
    fault = ($urandom_range(0, 7) == 0) ? hdr_fault_t'($urandom_range(1, 5)) : HDR_GOOD;
    if ($urandom_range(0, 9) == 0) begin
      put_header(16'($urandom), 16'($urandom), fault);
    end else begin
      put_header(16'(w - 1), 16'(h - 1), fault);
    end
    if ($urandom_range(0, 4) == 0) begin
      put_byte(pcxd_pkg::CMD_HEADER, 8'($urandom));
      put_byte(pcxd_pkg::CMD_PALETTE, 8'($urandom));
    end
    pixels = ($urandom_range(0, 4) == 0) ? $urandom_range(0, w * h - 1)
                                         : w * h + $urandom_range(0, 3);
    put_pixels(pixels);
    if ($urandom_range(0, 7) == 0) begin
      put_byte(pcxd_pkg::CMD_DATA, {pcxd_pkg::RUN_TAG, 6'($urandom)});
    end
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));
  endfunction

  // Byte driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      byte_ch.cmd <= pcxd_pkg::CMD_PALETTE;
      byte_ch.data_byte <= 8'h00;
      burst_left = 0;
      gap_left = 0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (byte_ch.valid) begin
        decode_byte(byte_ch.cmd, byte_ch.data_byte);
        bytes_taken++;
      end
      if (gap_left > 0) begin
        gap_left--;
        byte_ch.valid <= 1'b0;
      end else if (file_bytes.size() > 0) begin
        next_byte = file_bytes.pop_front();
        byte_ch.valid <= 1'b1;
        byte_ch.cmd <= next_byte.cmd;
        byte_ch.data_byte <= next_byte.data;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // Pixel receiver: free flow, coin flips, long stalls and light stalls in turn.
  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.ready <= 1'b0;
      rx_phase <= '0;
    end else begin
      rx_phase <= rx_phase + 10'd1;
      case (rx_phase[9:8])
        2'd0: pixel_ch.ready <= 1'b1;
        2'd1: pixel_ch.ready <= 1'($urandom_range(0, 1));
        2'd2: pixel_ch.ready <= (rx_phase[2:0] == 3'd0);
        default: pixel_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Each accepted pixel beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pixel_ch.valid && pixel_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected beat: rgb %h/%h/%h final %b status %0d w %0d h %0d",
                                pixel_ch.red, pixel_ch.green, pixel_ch.blue,
                                pixel_ch.final_pixel, pixel_ch.status,
                                pixel_ch.image_width, pixel_ch.image_height));
      end else begin
        want_px = expected_pixels.pop_front();
        if (pixel_ch.red !== want_px.red || pixel_ch.green !== want_px.green ||
            pixel_ch.blue !== want_px.blue || pixel_ch.final_pixel !== want_px.final_pixel ||
            pixel_ch.status !== want_px.status ||
            pixel_ch.image_width !== want_px.image_width ||
            pixel_ch.image_height !== want_px.image_height) begin
          note_mismatch({
            $sformatf("want rgb %h/%h/%h final %b status %0d w %0d h %0d",
                      want_px.red, want_px.green, want_px.blue, want_px.final_pixel,
                      want_px.status, want_px.image_width, want_px.image_height),
            $sformatf(", got rgb %h/%h/%h final %b status %0d w %0d h %0d",
                      pixel_ch.red, pixel_ch.green, pixel_ch.blue, pixel_ch.final_pixel,
                      pixel_ch.status, pixel_ch.image_width, pixel_ch.image_height)});
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.cmd = pcxd_pkg::CMD_PALETTE;
    byte_ch.data_byte = 8'h00;
    pixel_ch.ready = 1'b0;
    mismatches = 0;
    bytes_taken = 0;
    cycle_count = 0;
    clear_decode();

    // End of file with nothing read, after idle data bytes.
    put_byte(pcxd_pkg::CMD_DATA, 8'h00);
    put_byte(pcxd_pkg::CMD_DATA, 8'hff);
    put_byte(pcxd_pkg::CMD_EOF, 8'h00);
    put_byte(pcxd_pkg::CMD_EOF, 8'hff);

    // Header cut short, then headers that must be rejected.
    repeat (5) put_byte(pcxd_pkg::CMD_HEADER, 8'($urandom));
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));
    put_header(16'hffff, 16'd0, HDR_GOOD);
    put_byte(pcxd_pkg::CMD_DATA, 8'h41);
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));
    put_header(16'd0, 16'hffff, HDR_GOOD);
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));
    put_header(16'd1023, 16'd0, HDR_GOOD);
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));
    put_header(16'd0, 16'd1023, HDR_GOOD);
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));
    for (int f = BAD_MANUF; f <= BAD_PLANES; f++) begin
      put_header(16'd3, 16'd3, hdr_fault_t'(f));
      put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));
    end

    // Good header without a usable trailer: none, wrong marker, short.
    put_header(16'd2, 16'd2, HDR_GOOD);
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));
    put_trailer(TRAILER_BYTES, pcxd_pkg::PAL_MARKER ^ 8'h01, 1'b0);
    put_header(16'd2, 16'd2, HDR_GOOD);
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));
    put_trailer(100, pcxd_pkg::PAL_MARKER, 1'b0);
    put_header(16'd2, 16'd2, HDR_GOOD);
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));

    // A 4x2 image covering literals, a zero run, a run, an overlong run,
    // ignored late trailer and header bytes, and excess data.
    put_trailer(TRAILER_BYTES, pcxd_pkg::PAL_MARKER, 1'b1);
    put_byte(pcxd_pkg::CMD_PALETTE, 8'h5a);
    put_header(16'd3, 16'd1, HDR_GOOD);
    put_byte(pcxd_pkg::CMD_HEADER, 8'ha5);
    put_byte(pcxd_pkg::CMD_PALETTE, 8'h33);
    put_byte(pcxd_pkg::CMD_DATA, 8'h00);
    put_byte(pcxd_pkg::CMD_DATA, 8'hbf);
    put_byte(pcxd_pkg::CMD_DATA, {pcxd_pkg::RUN_TAG, 6'd0});
    put_byte(pcxd_pkg::CMD_DATA, 8'h05);
    put_byte(pcxd_pkg::CMD_DATA, {pcxd_pkg::RUN_TAG, 6'd2});
    put_byte(pcxd_pkg::CMD_DATA, 8'hff);
    put_byte(pcxd_pkg::CMD_DATA, {pcxd_pkg::RUN_TAG, 6'd63});
    put_byte(pcxd_pkg::CMD_DATA, 8'h80);
    put_byte(pcxd_pkg::CMD_DATA, 8'h12);
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));

    // Widest image, then tallest image cut off while a run waits for its value.
    put_trailer(TRAILER_BYTES, pcxd_pkg::PAL_MARKER, 1'b1);
    put_header(16'd1022, 16'd0, HDR_GOOD);
    put_pixels(1023);
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));
    put_trailer(TRAILER_BYTES, pcxd_pkg::PAL_MARKER, 1'b0);
    put_header(16'd0, 16'd1022, HDR_GOOD);
    put_pixels(500);
    put_byte(pcxd_pkg::CMD_DATA, {pcxd_pkg::RUN_TAG, 6'd5});
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));

    // Single pixel image.
    put_trailer(TRAILER_BYTES, pcxd_pkg::PAL_MARKER, 1'b1);
    put_header(16'd0, 16'd0, HDR_GOOD);
    put_byte(pcxd_pkg::CMD_DATA, 8'h01);
    put_byte(pcxd_pkg::CMD_EOF, 8'($urandom));

    repeat (12) put_random_image();
    bytes_total = file_bytes.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Let every byte go in and every expected pixel come out, then watch for strays.
    while (bytes_taken < bytes_total) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pcxd_pkg.sv
src/pcxd_if.sv
src/pcxd_palette_ram.sv
src/pcx_rle_palette_decoder.sv
tb/tb_top.sv
